FILE: rtl/x86_integer_alu_with_flags_unit_defines.svh
// Assertion macros shared by the RTL
`ifndef X86_INTEGER_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

`define ASSERT_IMPL(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/xalu_pkg.sv
`timescale 1ns / 1ps
package xalu_pkg;
	localparam int DataWidth = 32;
	localparam int WideWidth = 64;
	localparam int CntWidth = 7;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_ADC = 5'd1, OP_SUB = 5'd2, OP_SBB = 5'd3,
		OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_SHL = 5'd7,
		OP_SAL = 5'd8, OP_SHR = 5'd9, OP_SAR = 5'd10, OP_MUL = 5'd11,
		OP_IMUL = 5'd12, OP_DIV = 5'd13, OP_IDIV = 5'd14, OP_MOD = 5'd15,
		OP_IMOD = 5'd16
	} op_t;

	localparam logic [1:0] SIZE_8 = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;

	typedef struct packed {
		logic cf;
		logic pf;
		logic zf;
		logic sf;
		logic of;
	} flags_t;
endpackage

FILE: rtl/x86_integer_alu_with_flags_unit.sv
// Add/sub/logic, zero-count shifts, divide errors and unknown operations register
// their result on acceptance; other shifts pass ST_SHIFT, mul and imul ST_MUL, and
// divides ST_DIV and ST_FIX (one quotient bit per cycle, serial restoring loop).
// Throughput: one item at a time; the next is accepted once the result transfers.
// The output register allows a new item to enter in the cycle the result leaves.
// Reset (arst_n low, asynchronous): all flags clear, no result pending.
`timescale 1ns / 1ps
`include "x86_integer_alu_with_flags_unit_defines.svh"
module x86_integer_alu_with_flags_unit
	import xalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  req_type,
	input  logic [63:0] dest_operand,
	input  logic [63:0] src_operand,
	input  logic [1:0]  size_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_value,
	output logic        carry_out,
	output logic        parity_out,
	output logic        zero_out,
	output logic        sign_out,
	output logic        overflow_out,
	output logic        divide_error
);
	typedef enum logic [2:0] {ST_IDLE, ST_SHIFT, ST_MUL, ST_DIV, ST_FIX, ST_DONE} state_t;

	state_t        state_q;
	op_t           op_q;
	logic [1:0]    sc_q;
	logic [63:0]   a_q, b_q, acc_q;
	logic [64:0]   rem_q;
	logic [CntWidth-1:0] cnt_q;
	logic          neg_q, cf_sh_q, busy_q;
	flags_t        fl_q;
	logic [63:0]   res_q;
	logic          derr_out_q, ovalid_q;

	logic [5:0]  bits;
	logic [31:0] m32, sbm;
	logic [31:0] d, s;
	logic [32:0] full;
	logic [31:0] r32;
	logic [31:0] lres;
	logic [64:0] rtry;
	logic [63:0] ua, ub;
	logic [63:0] fix_val, fix_neg;
	logic        dn, sn;

	assign in_ready = !busy_q && (!ovalid_q || out_ready);
	assign bits = (size_code == SIZE_8) ? 6'd8 : (size_code == SIZE_16) ? 6'd16 : 6'd32;
	assign m32 = (size_code == SIZE_8) ? 32'hFF : (size_code == SIZE_16) ? 32'hFFFF
		: 32'hFFFF_FFFF;
	assign sbm = (m32 >> 1) + 32'd1;
	assign d = dest_operand[31:0] & m32;
	assign s = src_operand[31:0] & m32;
	assign lres = (req_type == OP_AND) ? (d & s) : (req_type == OP_OR) ? (d | s) : (d ^ s);
	assign dn = dest_operand[63];
	assign sn = src_operand[63];
	assign ua = dn ? (64'd0 - dest_operand) : dest_operand;
	assign ub = sn ? (64'd0 - src_operand) : src_operand;
	assign rtry = {rem_q[63:0], acc_q[63]} - {1'b0, b_q};
	assign fix_val = (op_q == OP_DIV || op_q == OP_IDIV) ? acc_q : rem_q[63:0];
	assign fix_neg = 64'd0 - fix_val;

	function automatic flags_t zsp(input flags_t f, input logic [31:0] r, input logic [1:0] sc);
		flags_t o;
		logic sgn;
		o = f;
		sgn = (sc == SIZE_8) ? r[7] : (sc == SIZE_16) ? r[15] : r[31];
		o.zf = (r == 32'd0);
		o.sf = sgn;
		o.pf = ~^r[7:0];
		return o;
	endfunction

	function automatic logic [31:0] szmask(input logic [1:0] sc);
		return (sc == SIZE_8) ? 32'hFF : (sc == SIZE_16) ? 32'hFFFF : 32'hFFFF_FFFF;
	endfunction

	function automatic logic [63:0] sx(input logic [31:0] v, input logic [1:0] sc);
		return (sc == SIZE_8) ? {{56{v[7]}}, v[7:0]} : (sc == SIZE_16) ?
			{{48{v[15]}}, v[15:0]} : {{32{v[31]}}, v};
	endfunction

	always_comb begin
		full = 33'd0;
		r32 = 32'd0;
		unique case (req_type)
			OP_ADD, OP_ADC: full = {1'b0, d} + {1'b0, s}
				+ {32'd0, (req_type == OP_ADC) & fl_q.cf};
			OP_SUB, OP_SBB: full = {1'b0, d} - {1'b0, s}
				- {32'd0, (req_type == OP_SBB) & fl_q.cf};
			default: full = 33'd0;
		endcase
		r32 = full[31:0] & m32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			ovalid_q <= 1'b0;
			fl_q <= '0;
			derr_out_q <= 1'b0;
			res_q <= '0;
			op_q <= OP_ADD;
			sc_q <= '0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			cf_sh_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready && !(in_valid && in_ready))
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= op_t'(req_type);
						sc_q <= size_code;
						unique case (req_type)
							OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
								res_q <= {32'd0, r32};
								fl_q <= zsp('{cf: (req_type == OP_ADD || req_type == OP_ADC)
									? full[bits] : full[32], pf: 1'b0, zf: 1'b0, sf: 1'b0,
									of: (req_type == OP_ADD || req_type == OP_ADC)
									? (((d ^ s) & sbm) == 0 && ((r32 ^ d) & sbm) != 0)
									: (((d ^ s) & sbm) != 0 && ((r32 ^ s) & sbm) == 0)},
									r32, size_code);
								derr_out_q <= 1'b0;
								ovalid_q <= 1'b1;
							end
							OP_AND, OP_OR, OP_XOR: begin
								res_q <= {32'd0, lres};
								fl_q <= zsp('{cf: 1'b0, pf: 1'b0, zf: 1'b0, sf: 1'b0,
									of: 1'b0}, lres, size_code);
								derr_out_q <= 1'b0;
								ovalid_q <= 1'b1;
							end
							OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
								if (src_operand[4:0] == 5'd0) begin
									res_q <= {32'd0, d};
									derr_out_q <= 1'b0;
									ovalid_q <= 1'b1;
								end else begin
									a_q <= (req_type == OP_SAR)
										? (sx(d, size_code) & 64'hFFFF_FFFF) : {32'd0, d};
									cnt_q <= CntWidth'(src_operand[4:0]);
									cf_sh_q <= 1'b0;
									state_q <= ST_SHIFT;
									busy_q <= 1'b1;
									ovalid_q <= 1'b0;
								end
							end
							OP_MUL, OP_IMUL: begin
								a_q <= (req_type == OP_MUL) ? {32'd0, d} : sx(d, size_code);
								b_q <= (req_type == OP_MUL) ? {32'd0, s} : sx(s, size_code);
								acc_q <= '0;
								cnt_q <= CntWidth'(WideWidth);
								state_q <= ST_MUL;
								busy_q <= 1'b1;
								ovalid_q <= 1'b0;
							end
							OP_DIV, OP_MOD, OP_IDIV, OP_IMOD: begin
								if (src_operand == 64'd0 || ((req_type == OP_IDIV ||
									req_type == OP_IMOD) && dest_operand ==
									64'h8000_0000_0000_0000 && src_operand == '1)) begin
									res_q <= '0;
									derr_out_q <= 1'b1;
									ovalid_q <= 1'b1;
								end else begin
									if (req_type == OP_DIV || req_type == OP_MOD) begin
										acc_q <= dest_operand;
										b_q <= src_operand;
										neg_q <= 1'b0;
									end else begin
										acc_q <= ua;
										b_q <= ub;
										neg_q <= (req_type == OP_IDIV) ? (dn != sn) : dn;
									end
									rem_q <= '0;
									cnt_q <= CntWidth'(WideWidth);
									state_q <= ST_DIV;
									busy_q <= 1'b1;
									ovalid_q <= 1'b0;
								end
							end
							default: begin
								res_q <= '0;
								derr_out_q <= 1'b0;
								ovalid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					if (cnt_q == '0) begin
						res_q <= {32'd0, a_q[31:0] & szmask(sc_q)};
						fl_q <= zsp('{cf: cf_sh_q, pf: 1'b0, zf: 1'b0, sf: 1'b0,
							of: fl_q.of}, a_q[31:0] & szmask(sc_q), sc_q);
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (op_q == OP_SHL || op_q == OP_SAL) begin
							cf_sh_q <= (sc_q == SIZE_8) ? a_q[7] : (sc_q == SIZE_16)
								? a_q[15] : a_q[31];
							a_q <= {32'd0, a_q[30:0], 1'b0};
						end else begin
							cf_sh_q <= a_q[0];
							a_q <= {32'd0, (op_q == OP_SAR) & a_q[31], a_q[31:1]};
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						res_q <= acc_q;
						if (op_q == OP_MUL) begin
							fl_q.cf <= (acc_q & ~{32'd0, szmask(sc_q)}) != 0;
							fl_q.of <= (acc_q & ~{32'd0, szmask(sc_q)}) != 0;
						end
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (b_q[0])
							acc_q <= acc_q + a_q;
						a_q <= {a_q[62:0], 1'b0};
						b_q <= {1'b0, b_q[63:1]};
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (!rtry[64]) begin
							rem_q <= rtry;
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= {rem_q[63:0], acc_q[63]};
							acc_q <= {acc_q[62:0], 1'b0};
						end
					end
				end
				ST_FIX: begin
					res_q <= {32'd0, neg_q ? fix_neg[31:0] : fix_val[31:0]};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					derr_out_q <= 1'b0;
					ovalid_q <= 1'b1;
					busy_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign result_value = res_q;
	assign carry_out = fl_q.cf;
	assign parity_out = fl_q.pf;
	assign zero_out = fl_q.zf;
	assign sign_out = fl_q.sf;
	assign overflow_out = fl_q.of;
	assign divide_error = derr_out_q;

	`ASSERT_IMPL(a_busy_blocks, busy_q |-> !in_ready, "input taken while busy")
	`ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped")
	`ASSERT_IMPL(a_derr_res, (out_valid && divide_error) |-> (result_value == 64'd0),
		"divide error with nonzero result")
endmodule

FILE: sim/x86_integer_alu_with_flags_unit_tb.sv
`timescale 1ns / 1ps
module x86_integer_alu_with_flags_unit_tb;
	import xalu_pkg::*;

	typedef struct {
		logic [4:0]  op;
		logic [63:0] dst;
		logic [63:0] src;
		logic [1:0]  sz;
	} alu_req_t;

	typedef struct {
		logic [63:0] value;
		flags_t      flags;
		logic        derr;
	} alu_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  req_type = '0;
	logic [63:0] dest_operand = '0;
	logic [63:0] src_operand = '0;
	logic [1:0]  size_code = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] result_value;
	logic        carry_out, parity_out, zero_out, sign_out, overflow_out, divide_error;

	alu_req_t pending_reqs[$];
	alu_res_t expected_results[$];
	flags_t   alu_flags;
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       hold_cycles = 0;
	bit       stim_done = 1'b0;
	bit       calm = 1'b0;

	x86_integer_alu_with_flags_unit u_top (.*);

	always #6 clk = ~clk;

	function automatic logic [63:0] sext_to64(logic [63:0] v, int bits);
		logic [63:0] m;
		m = (64'd1 << bits) - 64'd1;
		v &= m;
		return v[bits-1] ? (v | ~m) : v;
	endfunction

	function automatic void update_zsp(logic [63:0] r, int bits);
		alu_flags.zf = (r == 0);
		alu_flags.sf = r[bits-1];
		alu_flags.pf = ~^r[7:0];
	endfunction

	function automatic alu_res_t compute_alu(alu_req_t q);
		alu_res_t   e;
		int         bits;
		logic [63:0] m, sb, d, s, res, full, ua, ub, t64;
		logic [31:0] t;
		logic        cin, dn, sn;
		int         c;
		bits = (q.sz == SIZE_8) ? 8 : (q.sz == SIZE_16) ? 16 : 32;
		m = (64'd1 << bits) - 64'd1;
		sb = 64'd1 << (bits - 1);
		d = q.dst & m;
		s = q.src & m;
		res = '0;
		e.derr = 1'b0;
		case (q.op)
			OP_ADD, OP_ADC: begin
				cin = (q.op == OP_ADC) ? alu_flags.cf : 1'b0;
				full = d + s + cin;
				res = full & m;
				alu_flags.cf = full[bits];
				alu_flags.of = (((d ^ s) & sb) == 0) && (((res ^ d) & sb) != 0);
				update_zsp(res, bits);
			end
			OP_SUB, OP_SBB: begin
				cin = (q.op == OP_SBB) ? alu_flags.cf : 1'b0;
				res = (d - s - cin) & m;
				alu_flags.cf = d < s + cin;
				alu_flags.of = (((d ^ s) & sb) != 0) && (((res ^ s) & sb) == 0);
				update_zsp(res, bits);
			end
			OP_AND, OP_OR, OP_XOR: begin
				res = (q.op == OP_AND) ? (d & s) : (q.op == OP_OR) ? (d | s) : (d ^ s);
				alu_flags.cf = 1'b0;
				alu_flags.of = 1'b0;
				update_zsp(res, bits);
			end
			OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
				c = q.src[4:0];
				if (c == 0) begin
					res = d;
				end else begin
					if (q.op == OP_SHL || q.op == OP_SAL) begin
						t = 32'(d << (c - 1));
						alu_flags.cf = t[bits-1];
						res = ({32'd0, t} << 1) & m;
					end else if (q.op == OP_SHR) begin
						t = 32'(d >> (c - 1));
						alu_flags.cf = t[0];
						res = {32'd0, t >> 1} & m;
					end else begin
						t = 32'($signed(sext_to64(d, bits)) >>> (c - 1));
						alu_flags.cf = t[0];
						res = {32'd0, 32'($signed(t) >>> 1)} & m;
					end
					update_zsp(res, bits);
				end
			end
			OP_MUL: begin
				res = d * s;
				alu_flags.cf = (res >> bits) != 0;
				alu_flags.of = alu_flags.cf;
			end
			OP_IMUL: res = sext_to64(d, bits) * sext_to64(s, bits);
			OP_DIV, OP_MOD: begin
				if (q.src == 0) e.derr = 1'b1;
				else begin
					t64 = (q.op == OP_DIV) ? q.dst / q.src : q.dst % q.src;
					res = t64 & 64'hFFFF_FFFF;
				end
			end
			OP_IDIV, OP_IMOD: begin
				dn = q.dst[63];
				sn = q.src[63];
				ua = dn ? -q.dst : q.dst;
				ub = sn ? -q.src : q.src;
				if (q.src == 0 || (q.dst == 64'h8000_0000_0000_0000 && q.src == '1)) begin
					e.derr = 1'b1;
				end else if (q.op == OP_IDIV) begin
					t64 = ua / ub;
					res = ((dn != sn) ? -t64 : t64) & 64'hFFFF_FFFF;
				end else begin
					t64 = ua % ub;
					res = (dn ? -t64 : t64) & 64'hFFFF_FFFF;
				end
			end
			default: ;
		endcase
		e.value = res;
		e.flags = alu_flags;
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	function automatic logic [63:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom};
			3: return 64'(1) << $urandom_range(0, 63);
			4: return 64'($urandom_range(0, 300));
			default: return {32'd0, $urandom};
		endcase
	endfunction

	function automatic alu_req_t rand_req();
		alu_req_t q;
		int k;
		k = $urandom_range(0, 99);
		q.op = (k < 3) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
		q.sz = 2'($urandom_range(0, 3));
		q.dst = rand_operand();
		q.src = rand_operand();
		if (q.op >= OP_DIV && q.op <= OP_IMOD && $urandom_range(0, 3) == 0)
			q.src = 64'($urandom_range(1, 9));
		if (q.op >= OP_IDIV && $urandom_range(0, 19) == 0) begin
			q.dst = 64'h8000_0000_0000_0000;
			q.src = '1;
		end
		return q;
	endfunction

	task automatic push_req(logic [4:0] op, logic [63:0] d, logic [63:0] s, logic [1:0] sz);
		alu_req_t q;
		q.op = op;
		q.dst = d;
		q.src = s;
		q.sz = sz;
		pending_reqs.push_back(q);
	endtask

	initial begin
		op_t o;
		alu_flags = '0;
		push_req(OP_ADD, 64'hFF, 64'h01, SIZE_8);
		push_req(OP_ADC, 64'h7FFF, 64'h0, SIZE_16);
		push_req(OP_SUB, 64'h0, 64'h1, 2'd2);
		push_req(OP_SBB, 64'h8000_0000, 64'h0, 2'd3);
		push_req(OP_SHL, 64'h81, 64'd0, SIZE_8);
		push_req(OP_SAR, 64'h80, 64'd20, SIZE_8);
		push_req(OP_SHR, '1, 64'd31, 2'd2);
		push_req(OP_SAL, '1, 64'hFFFF_FFFF_FFFF_FFE9, SIZE_16);
		push_req(OP_MUL, '1, '1, 2'd2);
		push_req(OP_IMUL, 64'h80, 64'hFF, SIZE_8);
		push_req(OP_DIV, '1, 64'd0, 2'd2);
		push_req(OP_IDIV, 64'h8000_0000_0000_0000, '1, 2'd2);
		push_req(OP_IMOD, 64'h8000_0000_0000_0000, 64'd3, 2'd2);
		push_req(OP_DIV, '1, 64'd1, 2'd2);
		push_req(OP_MOD, '1, 64'd7, SIZE_8);
		push_req(5'd31, '1, '1, 2'd2);
		push_req(5'd17, 64'd0, 64'd0, SIZE_8);
		o = o.first();
		do begin
			push_req(o, {$urandom, $urandom}, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
			o = o.next();
		end while (o != o.first());
		repeat (1150) pending_reqs.push_back(rand_req());
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		calm <= (cycle_count > 3000 && cycle_count < 9000);
		if (cycle_count > 3_000_000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(compute_alu('{req_type, dest_operand, src_operand,
					size_code}));
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
					alu_req_t q;
					q = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= q.op;
					dest_operand <= q.dst;
					src_operand <= q.src;
					size_code <= q.sz;
				end else begin
					in_valid <= 1'b0;
					if (pending_reqs.size() == 0) stim_done <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transfer", result_value, 0);
				end else begin
					alu_res_t e;
					e = expected_results.pop_front();
					if (result_value !== e.value) report_mismatch("result", result_value, e.value);
					if ({carry_out, parity_out, zero_out, sign_out, overflow_out} !== e.flags)
						report_mismatch("flags", {carry_out, parity_out, zero_out, sign_out,
							overflow_out}, e.flags);
					if (divide_error !== e.derr) report_mismatch("divide_error", divide_error, e.derr);
				end
			end
			if (cycle_count == 1500) hold_cycles <= 400;
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(0, 99) >= 24;
			end
		end
	end

	initial begin
		wait (stim_done && !in_valid && expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
